>>> src/matrix4_vector_transform_core_defines.svh
// Assertion helpers for the transform core.
`ifndef MATRIX4_VECTOR_TRANSFORM_CORE_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mvt_pkg.sv
package mvt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM        = 4;
  localparam int IDX_W      = $clog2(DIM);

  // accumulator widths: product, pair sum, four-term sum
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // input tdata layout, lowest bit first
  localparam int ROW_LSB     = 0;
  localparam int COL_LSB     = ROW_LSB + IDX_W;
  localparam int VAL_LSB     = COL_LSB + IDX_W;
  localparam int VEC_LSB     = VAL_LSB + DATA_WIDTH;
  localparam int IN_BITS     = VEC_LSB + DIM * DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = DIM * DATA_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_e;

  typedef struct packed {
    req_e                  kind;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    word_t                 value;
    word_t [DIM-1:0]       vec;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam word_t            FIX_ONE    = DATA_WIDTH'(1) << FRAC_BITS;
  localparam word_t            FIX_ZERO   = '0;
  localparam word_t            WORD_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t            WORD_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

>>> src/matrix4_vector_transform_core.sv
// Path: an accepted transform beat passes through the queue, the multiply, the pair add, the final
//   add with rounding, then saturate into the output reg on its way to m_axis.
// Throughput: one beat per cycle, load or transform; a load beat yields no output beat.
// The sixteen parallel multipliers set the pace; output backpressure stalls the whole back end.
// Reset (rst_ni low, async): matrix returns to identity, queue empties, no output pending.
`include "matrix4_vector_transform_core_defines.svh"

module matrix4_vector_transform_core
  import mvt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row_index, col_index, entry_value, vec_x..vec_w
  input  logic                   s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic                   m_axis_tuser    // sat_flag
);

  qstat_t q_stat;
  item_t  in_item, q_item;
  logic   q_push, q_pop;

  mvt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat_i      (q_stat),
    .push_o        (q_push),
    .item_o        (in_item)
  );

  mvt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (in_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  mvt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `MVT_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
  `MVT_ASSERT_NEXT(a_count_track, 1'b1, q_stat.count == $past(q_stat.count) + QCNT_W'($past(q_push)) - QCNT_W'($past(q_pop)), "queue count drift")
  `MVT_ASSERT_NOW(a_stall_full, !s_axis_tready, q_stat.full, "input stalled with queue room")

endmodule

>>> src/mvt_front.sv
module mvt_front
  import mvt_pkg::*;
(
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // row_index, col_index, entry_value, vec_x..vec_w
  input  logic                  s_axis_tuser,   // req_type
  input  qstat_t                q_stat_i,
  output logic                  push_o,
  output item_t                 item_o
);

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_o.kind  = req_e'(s_axis_tuser);
    item_o.row   = s_axis_tdata[ROW_LSB +: IDX_W];
    item_o.col   = s_axis_tdata[COL_LSB +: IDX_W];
    item_o.value = s_axis_tdata[VAL_LSB +: DATA_WIDTH];
    for (int i = 0; i < DIM; i++) begin
      item_o.vec[i] = s_axis_tdata[VEC_LSB + i*DATA_WIDTH +: DATA_WIDTH];
    end
  end

endmodule

>>> src/mvt_queue.sv
module mvt_queue
  import mvt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

>>> src/mvt_back.sv
module mvt_back
  import mvt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qstat_t                 q_stat_i,
  input  item_t                  item_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic                   m_axis_tuser    // sat_flag
);

  word_t                   mat_q  [DIM][DIM];
  logic signed [PROD_W-1:0] prod_q [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_q [DIM][2];
  logic signed [SUM_W-1:0]  sum_q  [DIM];
  word_t                   out_q  [DIM];
  word_t                   out_d  [DIM];
  logic                    sat_q, sat_d;
  logic                    v1_q, v2_q, v3_q, out_valid_q;
  logic                    adv, take_xform, take_load;

  // whole pipe moves unless a result sits unclaimed in the output register
  assign adv        = !out_valid_q || m_axis_tready;
  assign pop_o      = adv && !q_stat_i.empty;
  assign take_xform = pop_o && (item_i.kind == REQ_XFORM);
  assign take_load  = pop_o && (item_i.kind == REQ_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat_q[r][c] <= (r == c) ? FIX_ONE : FIX_ZERO;
        end
      end
    end else if (take_load) begin
      mat_q[item_i.row][item_i.col] <= item_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= take_xform;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // round-half-up then saturate; in range when the result sign and all bits above it agree
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      if ((&sum_q[r][SUM_W-1 -: SUM_W-FRAC_BITS-DATA_WIDTH+1]) ||
          !(|sum_q[r][SUM_W-1 -: SUM_W-FRAC_BITS-DATA_WIDTH+1])) begin
        out_d[r] = sum_q[r][FRAC_BITS +: DATA_WIDTH];
      end else begin
        out_d[r] = sum_q[r][SUM_W-1] ? WORD_MIN : WORD_MAX;
        sat_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_q[r][c] <= $signed(mat_q[r][c]) * $signed(item_i.vec[c]);
        end
        pair_q[r][0] <= PAIR_W'(prod_q[r][0]) + PAIR_W'(prod_q[r][1]);
        pair_q[r][1] <= PAIR_W'(prod_q[r][2]) + PAIR_W'(prod_q[r][3]);
        sum_q[r]     <= SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]) + $signed(ROUND_HALF);
        out_q[r]     <= out_d[r];
      end
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = sat_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int r = 0; r < DIM; r++) begin
      m_axis_tdata[r*DATA_WIDTH +: DATA_WIDTH] = out_q[r];
    end
  end

endmodule
